// ===== hw/rtl/sfr_pkg.sv =====
// shared constants, result beat type and the crc-8 step for the frame receiver
// no dependencies
package sfr_pkg;

  localparam int unsigned TW         = 9;   // frame total, up to 511
  localparam int unsigned CAPW       = 7;   // beats per input item, up to 64
  localparam int unsigned RESULT_CAP = 64;

  localparam logic [7:0]  CRC_POLY     = 8'hD5;
  localparam logic [7:0]  MIN_LEN      = 8'd3;
  localparam logic [7:0]  OWN_ADDR_RST = 8'd234;
  localparam logic [15:0] IDLE_TMO_RST = 16'd100;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic REG_OWN_ADDR = 1'b0;
  localparam logic REG_IDLE_TMO = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic [6:0] frame_total;
    logic       for_us;
    logic       last;
  } res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sfr_ifs.sv =====
// valid/ready channel interfaces for the frame receiver input and result beats
// depends on nothing
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic [6:0] frame_total;
  logic       for_us;
  logic       last;

  modport source (output valid, frame_byte, byte_index, frame_total, for_us, last,
                  input ready);
  modport sink   (input valid, frame_byte, byte_index, frame_total, for_us, last,
                  output ready);
endinterface

// ===== hw/rtl/sfr_mem.sv =====
// frame byte buffer: one write port, one read port with registered data
// no package dependencies
module sfr_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sfr_seq.sv =====
// rescan sequencer: appends bytes, checks length and crc, emits frames, idle flush
// depends on sfr_pkg; drives the ports of sfr_mem
module sfr_seq
  import sfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64,
  parameter int unsigned MAX_LEN   = 62,
  parameter int unsigned AW        = 6,
  parameter int unsigned CW        = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    own_addr_i,
  input  logic [15:0]   idle_tmo_i,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output res_t          out_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN    = 4'd1;
  localparam logic [3:0] ST_LEN     = 4'd2;
  localparam logic [3:0] ST_CRC_RD  = 4'd3;
  localparam logic [3:0] ST_CRC_ACC = 4'd4;
  localparam logic [3:0] ST_CHK_RD  = 4'd5;
  localparam logic [3:0] ST_CHK     = 4'd6;
  localparam logic [3:0] ST_EM_RD   = 4'd7;
  localparam logic [3:0] ST_EM_OUT  = 4'd8;
  localparam logic [3:0] ST_DROP    = 4'd9;
  localparam logic [3:0] ST_FINISH  = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [15:0]     idle_q, idle_d;
  logic [TW-1:0]   total_q, total_d;
  logic [TW-1:0]   k_q, k_d;
  logic [TW-1:0]   idx_q, idx_d;
  logic [7:0]      crc_q, crc_d;
  logic [CAPW-1:0] emit_q, emit_d;
  logic            forus_q, forus_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;
  logic [15:0]     idle_inc;
  logic [TW-1:0]   len_total;
  logic            cur_forus;

  // circular buffer address of head plus an offset below two depths
  function automatic logic [AW-1:0] addr_at(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + (AW+1)'(off);
    if (s >= (AW+1)'(BUF_DEPTH)) begin
      s = s - (AW+1)'(BUF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign len_total = TW'(mem_rdata_i) + TW'(2);
  assign cur_forus = (idx_q == '0) ? (mem_rdata_i == own_addr_i) : forus_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    idle_d      = idle_q;
    total_d     = total_q;
    k_d         = k_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    emit_d      = emit_q;
    forus_d     = forus_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_at(head_q, fill_q);
    mem_wdata_o = in_byte_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_at(head_q, CW'(1));

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_BYTE) begin
            idle_d = '0;
            if (fill_q < CW'(BUF_DEPTH)) begin
              mem_we_o = 1'b1;
              fill_d   = fill_q + CW'(1);
            end
            emit_d  = '0;
            state_d = ST_SCAN;
          end else begin
            idle_d = idle_inc;
            if (fill_q != '0 && idle_inc > idle_tmo_i) begin
              fill_d = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (fill_q < CW'(2)) begin
          state_d = ST_FINISH;
        end else begin
          mem_re_o = 1'b1;
          state_d  = ST_LEN;
        end
      end
      ST_LEN: begin
        if (mem_rdata_i < MIN_LEN || mem_rdata_i > 8'(MAX_LEN)) begin
          head_d  = addr_at(head_q, CW'(1));
          fill_d  = fill_q - CW'(1);
          state_d = ST_SCAN;
        end else begin
          total_d = len_total;
          if (TW'(fill_q) < len_total) begin
            state_d = ST_FINISH;
          end else begin
            crc_d   = '0;
            k_d     = TW'(2);
            state_d = ST_CRC_RD;
          end
        end
      end
      ST_CRC_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = addr_at(head_q, CW'(k_q));
        state_d     = ST_CRC_ACC;
      end
      ST_CRC_ACC: begin
        crc_d = crc8_step(crc_q, mem_rdata_i);
        k_d   = k_q + TW'(1);
        // last covered byte sits at offset total minus two
        if (k_q == total_q - TW'(2)) begin
          state_d = ST_CHK_RD;
        end else begin
          state_d = ST_CRC_RD;
        end
      end
      ST_CHK_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = addr_at(head_q, CW'(total_q - TW'(1)));
        state_d     = ST_CHK;
      end
      ST_CHK: begin
        if (mem_rdata_i != crc_q) begin
          head_d  = addr_at(head_q, CW'(1));
          fill_d  = fill_q - CW'(1);
          state_d = ST_SCAN;
        end else begin
          idx_d   = '0;
          state_d = ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        if (emit_q >= CAPW'(RESULT_CAP)) begin
          state_d = ST_DROP;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = addr_at(head_q, CW'(idx_q));
          state_d     = ST_EM_OUT;
        end
      end
      ST_EM_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.frame_byte  = mem_rdata_i;
          out_d.byte_index  = idx_q[5:0];
          out_d.frame_total = total_q[6:0];
          out_d.for_us      = cur_forus;
          out_d.last        = (idx_q == total_q - TW'(1));
          forus_d           = cur_forus;
          emit_d            = emit_q + CAPW'(1);
          idx_d             = idx_q + TW'(1);
          if (idx_q == total_q - TW'(1)) begin
            state_d = ST_DROP;
          end else begin
            state_d = ST_EM_RD;
          end
        end
      end
      ST_DROP: begin
        head_d  = addr_at(head_q, CW'(total_q));
        fill_d  = fill_q - CW'(total_q);
        state_d = ST_SCAN;
      end
      ST_FINISH: begin
        if (fill_q >= CW'(BUF_DEPTH)) begin
          fill_d = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
      emit_q      <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    k_q     <= k_d;
    idx_q   <= idx_d;
    crc_q   <= crc_d;
    forus_q <= forus_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/serial_frame_resync_receiver.sv =====
// channel   dir  beat payload                                       handshake
// rx_i      in   func, rx_byte                                      valid/ready
// res_o     out  frame_byte, byte_index, frame_total, for_us, last  valid/ready
// cfg       in   cfg_idx_i, cfg_data_i                              cfg_we_i
//
// a tick is taken in idle; a byte starts a rescan whose steps read the length,
// each crc byte, the crc byte for the compare and each emitted byte in turn,
// all through the single read port of the frame buffer
// reset clears fill count, idle count and head; buffer contents are not cleared
// a stalled result beat holds the sequencer at the next emitted byte
// depends on sfr_pkg, sfr_ifs, sfr_mem, sfr_seq
module serial_frame_resync_receiver
  import sfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64,
  parameter int unsigned MAX_LEN   = 62
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfr_rx_if.sink      rx_i,
  sfr_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

  logic [7:0]    own_addr_q;
  logic [15:0]   idle_tmo_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  res_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OWN_ADDR_RST;
      idle_tmo_q <= IDLE_TMO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_ADDR: own_addr_q <= cfg_data_i[7:0];
        REG_IDLE_TMO: idle_tmo_q <= cfg_data_i;
        default:      own_addr_q <= own_addr_q;
      endcase
    end
  end

  sfr_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sfr_seq #(
    .BUF_DEPTH (BUF_DEPTH),
    .MAX_LEN   (MAX_LEN),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .own_addr_i  (own_addr_q),
    .idle_tmo_i  (idle_tmo_q),
    .in_valid_i  (rx_i.valid),
    .in_func_i   (rx_i.func),
    .in_byte_i   (rx_i.rx_byte),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign res_o.frame_byte  = res.frame_byte;
  assign res_o.byte_index  = res.byte_index;
  assign res_o.frame_total = res.frame_total;
  assign res_o.for_us      = res.for_us;
  assign res_o.last        = res.last;

  // a byte beat always starts a rescan, so input is held off next cycle
  a_byte_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.valid && rx_i.ready && rx_i.func == FUNC_BYTE |=> !rx_i.ready)
    else $error("input ready right after a byte beat");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.last |-> res_o.byte_index == 6'(res_o.frame_total - 7'd1))
    else $error("last beat index does not match frame total");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.byte_index == 6'd0 |-> !res_o.last)
    else $error("first beat of a frame flagged last");

endmodule

// ===== sim/serial_frame_resync_receiver_tb.sv =====
// testbench for the serial frame receiver: random and directed byte/tick beats,
// a behavioral frame predictor and an in-order check of every result beat
// depends on sfr_pkg, sfr_ifs and serial_frame_resync_receiver
`timescale 1ns / 100ps

module serial_frame_resync_receiver_tb;
  import sfr_pkg::*;

  localparam int DEPTH   = 64;
  localparam int LEN_MAX = 62;
  localparam int LIMIT   = 3000000;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } rx_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_OWN_ADDR;
  logic [15:0] cfg_data_i = '0;

  sfr_rx_if rx();
  sfr_res_if res();

  serial_frame_resync_receiver u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .rx_i(rx.sink), .res_o(res.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  buf_mdl [DEPTH];
  int          fill_mdl;
  int unsigned idle_mdl;
  logic [7:0]  own_addr_mdl;
  logic [15:0] tmo_mdl;

  rx_beat_t pending_q[$];
  res_t     frames_due_q[$];
  int       errors;
  int       send_idle_pct, recv_stall_pct;
  bit       hold_recv;
  longint   cycles;

  function automatic logic [7:0] crc_of(const ref logic [7:0] b[DEPTH], input int n);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < n; i++) begin
      c ^= b[2 + i];
      for (int k = 0; k < 8; k++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'hD5) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_list(input logic [7:0] d[$]);
    logic [7:0] c;
    c = 8'h00;
    foreach (d[i]) begin
      c ^= d[i];
      for (int k = 0; k < 8; k++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'hD5) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic drop_head(input int n);
    if (n >= fill_mdl) begin
      fill_mdl = 0;
    end else begin
      for (int i = 0; i < fill_mdl - n; i++) buf_mdl[i] = buf_mdl[i + n];
      fill_mdl -= n;
    end
  endtask

  task automatic predict_frames(input rx_beat_t it);
    int len, tot, nres;
    res_t r;
    nres = 0;
    if (it.func == FUNC_BYTE) begin
      idle_mdl = 0;
      if (fill_mdl < DEPTH) begin
        buf_mdl[fill_mdl] = it.rx_byte;
        fill_mdl++;
      end
      forever begin
        if (fill_mdl < 2) break;
        len = buf_mdl[1];
        if (len < 3 || len > LEN_MAX) begin
          drop_head(1);
          continue;
        end
        tot = len + 2;
        if (fill_mdl < tot) break;
        if (crc_of(buf_mdl, len - 1) != buf_mdl[tot - 1]) begin
          drop_head(1);
          continue;
        end
        for (int i = 0; i < tot; i++) begin
          if (nres >= RESULT_CAP) break;
          r.frame_byte  = buf_mdl[i];
          r.byte_index  = i[5:0];
          r.frame_total = tot[6:0];
          r.for_us      = (buf_mdl[0] == own_addr_mdl);
          r.last        = (i + 1 == tot);
          frames_due_q.push_back(r);
          nres++;
        end
        drop_head(tot);
      end
      if (fill_mdl >= DEPTH) fill_mdl = 0;
    end else begin
      if (idle_mdl < 65535) idle_mdl++;
      if (fill_mdl > 0 && idle_mdl > tmo_mdl) fill_mdl = 0;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rx.valid && rx.ready) begin
      predict_frames(pending_q.pop_front());
    end
    if ((!rx.valid || rx.ready) ) begin
      if (rx.valid && rx.ready && pending_q.size() == 0) begin
        rx.valid <= 1'b0;
      end else if (rx.valid && !rx.ready) begin
        // hold current beat
      end else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx.valid   <= 1'b1;
        rx.func    <= pending_q[0].func;
        rx.rx_byte <= pending_q[0].rx_byte;
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t exp_r;
    if (res.valid && res.ready) begin
      if (frames_due_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h/%0d/%0d/%0d/%0d", $time,
                 res.frame_byte, res.byte_index, res.frame_total, res.for_us, res.last);
        errors++;
      end else begin
        exp_r = frames_due_q.pop_front();
        if (res.frame_byte != exp_r.frame_byte || res.byte_index != exp_r.byte_index ||
            res.frame_total != exp_r.frame_total || res.for_us != exp_r.for_us ||
            res.last != exp_r.last) begin
          $display("%0t beat mismatch: expected %h/%0d/%0d/%0d/%0d, actual %h/%0d/%0d/%0d/%0d",
                   $time, exp_r.frame_byte, exp_r.byte_index, exp_r.frame_total,
                   exp_r.for_us, exp_r.last, res.frame_byte, res.byte_index,
                   res.frame_total, res.for_us, res.last);
          errors++;
        end
      end
    end
    res.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_q.push_back('{func: FUNC_BYTE, rx_byte: b});
  endtask

  task automatic push_tick();
    pending_q.push_back('{func: FUNC_TICK, rx_byte: 8'($urandom)});
  endtask

  // well-formed frame, optionally corrupted crc
  task automatic push_frame(input logic [7:0] addr, input int len, input bit bad_crc);
    logic [7:0] body[$];
    logic [7:0] c;
    for (int i = 0; i < len - 1; i++) body.push_back(8'($urandom));
    c = crc_list(body);
    if (bad_crc) c ^= 8'(1 << $urandom_range(7));
    push_byte(addr);
    push_byte(8'(len));
    foreach (body[i]) push_byte(body[i]);
    push_byte(c);
  endtask

  // wait until all beats are out and the block is back waiting for input
  task automatic drain();
    while (pending_q.size() != 0 || rx.valid || frames_due_q.size() != 0 || !rx.ready)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_OWN_ADDR) own_addr_mdl = val[7:0];
    else tmo_mdl = val;
  endtask

  task automatic random_phase(input int n);
    int k, sel, len;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        len = ($urandom_range(9) == 0) ? int'($urandom_range(3, LEN_MAX))
                                       : int'($urandom_range(3, 8));
        push_frame(($urandom_range(1)) ? own_addr_mdl : 8'($urandom), len, 1'b0);
        k += len + 2;
      end else if (sel < 70) begin
        len = int'($urandom_range(3, 8));
        push_frame(8'($urandom), len, 1'b1);
        k += len + 2;
      end else if (sel < 90) begin
        push_byte(8'($urandom));
        k++;
      end else begin
        push_tick();
        k++;
      end
    end
  endtask

  initial begin
    rx.valid = 1'b0;
    rx.func = FUNC_BYTE;
    rx.rx_byte = '0;
    res.ready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fill_mdl = 0;
    idle_mdl = 0;
    own_addr_mdl = OWN_ADDR_RST;
    tmo_mdl = IDLE_TMO_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, bad length, bad crc, back-to-back frames, timeout
    push_frame(OWN_ADDR_RST, 3, 1'b0);
    push_frame(8'h00, 3, 1'b0);
    push_byte(8'hFF);
    push_byte(8'h02);
    push_byte(8'd63);
    push_frame(8'hFF, 4, 1'b1);
    push_frame(8'hFF, 4, 1'b0);
    push_byte(8'hC8);
    push_byte(8'd5);
    push_tick();
    push_tick();
    drain();
    write_reg(REG_IDLE_TMO, 16'd0);
    push_byte(8'hEA);
    push_tick();
    push_frame(8'h12, 3, 1'b0);
    drain();
    write_reg(REG_IDLE_TMO, 16'hFFFF);
    write_reg(REG_OWN_ADDR, 16'h0000);
    push_frame(8'h00, LEN_MAX, 1'b0);
    // a little junk after the longest frame, then a tick that must not flush
    for (int i = 0; i < 4; i++) push_byte(8'd10);
    push_tick();
    drain();

    write_reg(REG_OWN_ADDR, 16'h00FF);
    write_reg(REG_IDLE_TMO, 16'd3);
    random_phase(12);
    drain();

    send_idle_pct = 65;
    write_reg(REG_IDLE_TMO, 16'd1);
    random_phase(12);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 65;
    write_reg(REG_OWN_ADDR, 16'h0055);
    write_reg(REG_IDLE_TMO, 16'd100);
    random_phase(12);
    // long hold-off while the sender keeps offering frames
    hold_recv = 1'b1;
    for (int i = 0; i < 3; i++) push_frame(8'h55, 5, 1'b0);
    repeat (2000) @(posedge clk_i);
    hold_recv = 1'b0;
    drain();

    send_idle_pct = 31;
    recv_stall_pct = 31;
    random_phase(12);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_ifs.sv
hw/rtl/sfr_mem.sv
hw/rtl/sfr_seq.sv
hw/rtl/serial_frame_resync_receiver.sv
sim/serial_frame_resync_receiver_tb.sv
